// ===== design/mme_pkg.sv =====
// shared constants and types of the matrix multiply engine
package mme_pkg;

    localparam int MAX_ROWS  = 8;
    localparam int MAX_INNER = 8;
    localparam int MAX_COLS  = 8;

    localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
    localparam int B_DEPTH = MAX_INNER * MAX_COLS;
    localparam int A_AW    = $clog2(A_DEPTH);
    localparam int B_AW    = $clog2(B_DEPTH);

    localparam int DIM_W = 4;
    localparam int IDX_W = 3;
    localparam int ACC_W = 64 + $clog2(MAX_INNER);

    localparam logic [1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [1:0] MODE_COMPUTE = 2'd2;

    localparam logic [1:0] CFG_ROWS_A = 2'd0;
    localparam logic [1:0] CFG_INNER  = 2'd1;
    localparam logic [1:0] CFG_COLS_B = 2'd2;

    typedef struct packed {
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_meta;

    typedef struct packed {
        logic             valid;
        t_meta            meta;
        logic [ACC_W-1:0] sum;
    } t_link;

endpackage

// ===== design/matrix_multiply_engine.sv =====
// top level of the matrix multiply engine: stores, sequencer, cell chain, output register
//
//  channel   direction  handshake             payload
//  s         in         i_s_tvalid/o_s_tready tdata element_value, tuser mode
//  m         out        o_m_tvalid/i_m_tready tdata row, col, product_value; tlast
//  cfg       in         i_cfg_valid/o_cfg_ready index, data (4 bits)
//
// a load request is taken while idle; a compute request walks every row of A into the cells and then
// every column of B past them, one A or B word a cycle while the result is not stalled, as set by the
// single read port of each store; new requests are taken once the cell chain has drained.
// reset is synchronous, clears counters and valid flags and sets the sizes to eight;
// the stores are not cleared.
// a stalled result freezes the whole compute pipeline until it is taken.
module matrix_multiply_engine import mme_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] element_value
    input  logic [1:0]  i_s_tuser,   // [1:0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [2:0] result_row, [5:3] result_col,
                                     // [69:6] product_value, [71:70] zero
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_AROW  = 2'd1;
    localparam logic [1:0] S_BCOL  = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end
        return res;
    endfunction

    logic [1:0]        r_state;
    logic [DIM_W-1:0]  r_rows_a, r_inner, r_cols_b;
    logic [DIM_W-1:0]  w_nr, w_ni, w_nc;
    logic [DIM_W-1:0]  w_nr_m1, w_ni_m1, w_nc_m1;
    logic [6:0]        r_cnt_a, r_cnt_b;
    logic [7:0]        w_a_lim, w_b_lim;
    logic [IDX_W-1:0]  r_r, r_c, r_k;
    logic              w_last_k, w_last_c, w_last_r;
    logic              w_in_acc, w_wr_a, w_wr_b, w_adv;
    logic [A_AW-1:0]   w_a_raddr;
    logic [B_AW-1:0]   w_b_raddr;

    logic [31:0]       r_a_mem [A_DEPTH];
    logic [31:0]       r_b_mem [B_DEPTH];
    logic signed [31:0] r_a_rdata, r_b_rdata;

    logic              r_rd_va, r_rd_vb;
    logic [IDX_W-1:0]  r_rd_k;
    t_meta             r_rd_meta;
    logic              r_m2_valid;
    t_meta             r_m2_meta;

    t_link             w_link [MAX_INNER+1];
    logic [MAX_INNER-1:0] w_cell_valid, w_a_load_vec, w_b_hit_vec;
    logic              w_any_valid;
    t_link             w_tail;
    logic              w_fits;
    logic [63:0]       w_sat;

    logic              r_out_valid;
    t_meta             r_out_meta;
    logic [63:0]       r_out_value;

    // sizes in force
    assign w_nr    = clamp_dim(r_rows_a, DIM_W'(MAX_ROWS));
    assign w_ni    = clamp_dim(r_inner, DIM_W'(MAX_INNER));
    assign w_nc    = clamp_dim(r_cols_b, DIM_W'(MAX_COLS));
    assign w_nr_m1 = w_nr - DIM_W'(1);
    assign w_ni_m1 = w_ni - DIM_W'(1);
    assign w_nc_m1 = w_nc - DIM_W'(1);
    assign w_a_lim = 8'(w_nr) * 8'(w_ni);
    assign w_b_lim = 8'(w_ni) * 8'(w_nc);

    assign w_last_k = ({1'b0, r_k} == w_ni_m1);
    assign w_last_c = ({1'b0, r_c} == w_nc_m1);
    assign w_last_r = ({1'b0, r_r} == w_nr_m1);

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_wr_a = w_in_acc && (i_s_tuser == MODE_LOAD_A) && ({1'b0, r_cnt_a} < w_a_lim);
    assign w_wr_b = w_in_acc && (i_s_tuser == MODE_LOAD_B) && ({1'b0, r_cnt_b} < w_b_lim);
    assign w_adv  = !r_out_valid || i_m_tready;

    assign w_a_raddr = A_AW'(r_r) * A_AW'(w_ni) + A_AW'(r_k);
    assign w_b_raddr = B_AW'(r_k) * B_AW'(w_nc) + B_AW'(r_c);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= DIM_W'(8);
            r_inner  <= DIM_W'(8);
            r_cols_b <= DIM_W'(8);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROWS_A: r_rows_a <= i_cfg_data;
                CFG_INNER:  r_inner  <= i_cfg_data;
                CFG_COLS_B: r_cols_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: per row, walk the A row into the cells, then every column of B
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_r     <= '0;
            r_c     <= '0;
            r_k     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_wr_a) begin
                        r_cnt_a <= r_cnt_a + 7'd1;
                    end
                    if (w_wr_b) begin
                        r_cnt_b <= r_cnt_b + 7'd1;
                    end
                    if (w_in_acc && i_s_tuser == MODE_COMPUTE) begin
                        r_cnt_a <= '0;
                        r_cnt_b <= '0;
                        r_r     <= '0;
                        r_c     <= '0;
                        r_k     <= '0;
                        r_state <= S_AROW;
                    end
                end
                S_AROW: begin
                    if (w_adv) begin
                        if (w_last_k) begin
                            r_k     <= '0;
                            r_c     <= '0;
                            r_state <= S_BCOL;
                        end else begin
                            r_k <= r_k + IDX_W'(1);
                        end
                    end
                end
                S_BCOL: begin
                    if (w_adv) begin
                        if (w_last_k) begin
                            r_k <= '0;
                            if (w_last_c) begin
                                r_c <= '0;
                                if (w_last_r) begin
                                    r_state <= S_DRAIN;
                                end else begin
                                    r_r     <= r_r + IDX_W'(1);
                                    r_state <= S_AROW;
                                end
                            end else begin
                                r_c <= r_c + IDX_W'(1);
                            end
                        end else begin
                            r_k <= r_k + IDX_W'(1);
                        end
                    end
                end
                S_DRAIN: begin
                    if (!w_any_valid) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // element stores
    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_a_mem[r_cnt_a[A_AW-1:0]] <= i_s_tdata;
        end
        if (w_wr_b) begin
            r_b_mem[r_cnt_b[B_AW-1:0]] <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_rdata <= r_a_mem[w_a_raddr];
            r_b_rdata <= r_b_mem[w_b_raddr];
            r_rd_k    <= r_k;
            r_rd_meta <= '{last: w_last_r && w_last_c, row: r_r, col: r_c};
            r_m2_meta <= r_rd_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_va    <= 1'b0;
            r_rd_vb    <= 1'b0;
            r_m2_valid <= 1'b0;
        end else if (w_adv) begin
            r_rd_va    <= (r_state == S_AROW);
            r_rd_vb    <= (r_state == S_BCOL);
            // a column's partial sum enters the chain when its first product is ready
            r_m2_valid <= r_rd_vb && (r_rd_k == '0);
        end
    end

    assign w_link[0] = '{valid: r_m2_valid, meta: r_m2_meta, sum: '0};

    for (genvar i = 0; i < MAX_INNER; i++) begin : g_cell
        assign w_a_load_vec[i] = r_rd_va && (r_rd_k == IDX_W'(i));
        assign w_b_hit_vec[i]  = r_rd_vb && (r_rd_k == IDX_W'(i));
        assign w_cell_valid[i] = w_link[i+1].valid;

        mme_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_a_load (w_a_load_vec[i]),
            .i_b_hit  (w_b_hit_vec[i]),
            .i_a_data (r_a_rdata),
            .i_b_data (r_b_rdata),
            .i_prev   (w_link[i]),
            .o_next   (w_link[i+1])
        );
    end

    assign w_any_valid = r_rd_va || r_rd_vb || r_m2_valid || (|w_cell_valid);

    // saturate the wide sum to signed 64 bits
    assign w_tail = w_link[MAX_INNER];
    assign w_fits = (&w_tail.sum[ACC_W-1:63]) || !(|w_tail.sum[ACC_W-1:63]);
    assign w_sat  = w_fits ? w_tail.sum[63:0] :
                    (w_tail.sum[ACC_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_tail.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_meta  <= w_tail.meta;
            r_out_value <= w_sat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_value, r_out_meta.col, r_out_meta.row};
    assign o_m_tlast  = r_out_meta.last;

    // at most one cell takes an A word or a product in any cycle
    a_one_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_a_load_vec) && $onehot0(w_b_hit_vec))
        else $error("more than one cell selected");

    // a compute request starts the row walk
    a_compute_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_tuser == MODE_COMPUTE) |=> (r_state == S_AROW))
        else $error("compute request did not start the walk");

    // a held result stays unchanged until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("held result changed");

    // a held result freezes the read stage
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($stable(r_rd_vb) && $stable(r_rd_k)))
        else $error("pipeline moved under a stalled result");

endmodule

// ===== design/mme_cell.sv =====
// one multiply-accumulate cell of the partial-sum chain
module mme_cell import mme_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_a_load,
    input  logic               i_b_hit,
    input  logic signed [31:0] i_a_data,
    input  logic signed [31:0] i_b_data,
    input  t_link              i_prev,
    output t_link              o_next
);

    logic signed [31:0]      r_a;
    logic signed [63:0]      r_p;
    logic                    r_pv;
    logic                    r_valid;
    t_meta                   r_meta;
    logic [ACC_W-1:0]        r_sum;
    logic signed [63:0]      w_prod;
    logic [ACC_W-1:0]        w_add;

    assign w_prod = r_a * i_b_data;
    assign w_add  = r_pv ? {{(ACC_W-64){r_p[63]}}, r_p} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_pv    <= i_b_hit;
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_a_load) begin
                r_a <= i_a_data;
            end
            if (i_b_hit) begin
                r_p <= w_prod;
            end
            r_meta <= i_prev.meta;
            // the product latched in r_p meets its column's partial sum here
            r_sum  <= i_prev.sum + w_add;
        end
    end

    assign o_next = '{valid: r_valid, meta: r_meta, sum: r_sum};

endmodule
